@@ design/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// shared types and constants of the look-at view matrix block
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               origin;
    } t_lav_item;

endpackage

@@ design/lav_front.sv @@
// ----------------------------------------------------------------------------
// lav_front
// accepts a position transaction, flags the origin case, hands it to the queue
// ----------------------------------------------------------------------------
module lav_front import lav_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_full,
    output logic               o_busy,
    output logic               o_push,
    output t_lav_item          o_item
);

    logic      r_valid;
    t_lav_item r_item;

    assign o_push = r_valid && !i_full;
    assign o_busy = r_valid && i_full;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_item.px     <= i_pos_x;
            r_item.py     <= i_pos_y;
            r_item.pz     <= i_pos_z;
            r_item.origin <= (i_pos_x == 32'sd0) && (i_pos_y == 32'sd0) && (i_pos_z == 32'sd0);
        end
    end

endmodule

@@ design/lav_queue.sv @@
// ----------------------------------------------------------------------------
// lav_queue
// short queue between front and back
// ----------------------------------------------------------------------------
module lav_queue import lav_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_lav_item i_item,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_lav_item o_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_lav_item         r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ design/lav_isqrt.sv @@
// ----------------------------------------------------------------------------
// lav_isqrt
// bit-serial integer square root of a 64-bit value, two radicand bits a cycle
// ----------------------------------------------------------------------------
module lav_isqrt import lav_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        fit;

    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fit    = (rem_sh >= trial);
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= fit ? 34'(rem_sh - trial) : rem_sh[33:0];
            r_root <= {r_root[30:0], fit};
        end
    end

endmodule

@@ design/lav_back.sv @@
// ----------------------------------------------------------------------------
// lav_back
// sequencer that builds the view matrix: shared multiplier and accumulator,
// bit-serial divider, square root unit, row output register
// ----------------------------------------------------------------------------
module lav_back import lav_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_lav_item          i_item,
    output logic               o_pop,
    output logic               o_strobe,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_WB, ST_SQRT, ST_DIV, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        JB_SQV, JB_SQS, JB_U0, JB_U1, JB_U2, JB_T0, JB_T1, JB_T2
    } t_job;

    t_state             r_state;
    t_job               r_job;
    logic [1:0]         r_k;
    logic               r_neg;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_acc;

    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [32:0] r_v0, r_v1, r_v2;
    logic signed [17:0] r_sx, r_sz;
    logic signed [18:0] r_u0, r_u1, r_u2;
    logic signed [31:0] r_t0, r_t1, r_t2;

    logic [31:0]        r_n;
    logic               r_dsel_s;
    logic [1:0]         r_didx;
    logic               r_dload;
    logic               r_dneg;
    logic [4:0]         r_dcnt;
    logic [31:0]        r_rem;
    logic [16:0]        r_dnum;
    logic [16:0]        r_q;

    logic [1:0]         r_row;
    logic               r_strobe;
    logic [1:0]         r_row_index;
    logic signed [31:0] r_col0, r_col1, r_col2, r_col3;
    logic               r_last_row;

    logic signed [32:0] mul_a, mul_b;
    logic               mul_neg;
    logic [1:0]         n_terms;
    logic signed [65:0] mul_p;
    logic signed [32:0] v_k, p_k, u_k;

    logic signed [65:0] acc_adj;
    logic signed [49:0] acc_q;
    logic signed [31:0] acc_sat;

    logic signed [32:0] div_w;
    logic [31:0]        div_mag;
    logic [47:0]        div_num;
    logic [32:0]        div_sh;
    logic               div_fit;
    logic [16:0]        div_qn;
    logic signed [17:0] div_res;
    logic               div_last;

    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;

    assign o_pop       = (r_state == ST_IDLE) && i_valid;
    assign o_strobe    = r_strobe;
    assign o_row_index = r_row_index;
    assign o_col0      = r_col0;
    assign o_col1      = r_col1;
    assign o_col2      = r_col2;
    assign o_col3      = r_col3;
    assign o_last_row  = r_last_row;

    // term operands
    always_comb begin
        case (r_k)
            2'd0:    begin v_k = r_v0; p_k = 33'(r_px); u_k = 33'(r_u0); end
            2'd1:    begin v_k = r_v1; p_k = 33'(r_py); u_k = 33'(r_u1); end
            default: begin v_k = r_v2; p_k = 33'(r_pz); u_k = 33'(r_u2); end
        endcase
        mul_a   = v_k;
        mul_b   = v_k;
        mul_neg = 1'b0;
        n_terms = 2'd3;
        case (r_job)
            JB_SQV: begin
                mul_a = v_k; mul_b = v_k; n_terms = 2'd3;
            end
            JB_SQS: begin
                mul_a = (r_k == 2'd0) ? 33'(r_sx) : 33'(r_sz);
                mul_b = mul_a;
                n_terms = 2'd2;
            end
            JB_U0: begin
                mul_a = 33'(r_sz); mul_b = r_v1; mul_neg = 1'b1; n_terms = 2'd1;
            end
            JB_U1: begin
                mul_a   = (r_k == 2'd0) ? 33'(r_sz) : 33'(r_sx);
                mul_b   = (r_k == 2'd0) ? r_v0 : r_v2;
                mul_neg = (r_k != 2'd0);
                n_terms = 2'd2;
            end
            JB_U2: begin
                mul_a = 33'(r_sx); mul_b = r_v1; n_terms = 2'd1;
            end
            JB_T0: begin
                mul_a   = (r_k == 2'd0) ? 33'(r_sx) : 33'(r_sz);
                mul_b   = (r_k == 2'd0) ? 33'(r_px) : 33'(r_pz);
                mul_neg = 1'b1;
                n_terms = 2'd2;
            end
            JB_T1: begin
                mul_a = u_k; mul_b = p_k; mul_neg = 1'b1; n_terms = 2'd3;
            end
            default: begin
                mul_a = v_k; mul_b = p_k; n_terms = 2'd3;
            end
        endcase
    end

    assign mul_p = 66'(mul_a) * 66'(mul_b);

    // truncating divide by 1.0 and saturation
    assign acc_adj = r_acc + (r_acc[65] ? 66'sd65535 : 66'sd0);
    assign acc_q   = acc_adj[65:16];
    always_comb begin
        if (acc_q > 50'sd2147483647) begin
            acc_sat = 32'sh7fffffff;
        end else if (acc_q < -50'sd2147483648) begin
            acc_sat = 32'sh80000000;
        end else begin
            acc_sat = acc_q[31:0];
        end
    end

    // divider operand and step
    always_comb begin
        if (!r_dsel_s) begin
            case (r_didx)
                2'd0:    div_w = r_v0;
                2'd1:    div_w = r_v1;
                default: div_w = r_v2;
            endcase
            div_last = (r_didx == 2'd2);
        end else begin
            div_w    = (r_didx == 2'd0) ? 33'(r_sx) : 33'(r_sz);
            div_last = (r_didx == 2'd1);
        end
    end

    assign div_mag = div_w[32] ? 32'(-div_w) : div_w[31:0];
    assign div_num = {div_mag, 16'h0000};
    assign div_sh  = {r_rem, r_dnum[16]};
    assign div_fit = (div_sh >= {1'b0, r_n});
    assign div_qn  = {r_q[15:0], div_fit};
    assign div_res = r_dneg ? -$signed({1'b0, div_qn}) : $signed({1'b0, div_qn});

    assign sq_start = (r_state == ST_WB) && ((r_job == JB_SQV) || (r_job == JB_SQS))
                      && (r_acc != 66'sd0);

    lav_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_acc[63:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_px  <= i_item.px;
                        r_py  <= i_item.py;
                        r_pz  <= i_item.pz;
                        r_v0  <= -33'(i_item.px);
                        r_v1  <= -33'(i_item.py);
                        r_v2  <= -33'(i_item.pz);
                        r_sx  <= '0;
                        r_sz  <= '0;
                        r_k   <= '0;
                        r_job <= i_item.origin ? JB_SQS : JB_SQV;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (r_k < n_terms) begin
                        r_prod <= mul_p;
                        r_neg  <= mul_neg;
                    end
                    if (r_k == 2'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_neg ? r_acc - r_prod : r_acc + r_prod;
                    end
                    if (r_k == n_terms) begin
                        r_state <= ST_WB;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_WB: begin
                    r_k <= '0;
                    case (r_job)
                        JB_SQV: begin
                            if (r_acc == 66'sd0) begin
                                r_job   <= JB_SQS;
                                r_state <= ST_MAC;
                            end else begin
                                r_dsel_s <= 1'b0;
                                r_state  <= ST_SQRT;
                            end
                        end
                        JB_SQS: begin
                            if (r_acc == 66'sd0) begin
                                r_job   <= JB_U0;
                                r_state <= ST_MAC;
                            end else begin
                                r_dsel_s <= 1'b1;
                                r_state  <= ST_SQRT;
                            end
                        end
                        JB_U0: begin
                            r_u0 <= acc_q[18:0]; r_job <= JB_U1; r_state <= ST_MAC;
                        end
                        JB_U1: begin
                            r_u1 <= acc_q[18:0]; r_job <= JB_U2; r_state <= ST_MAC;
                        end
                        JB_U2: begin
                            r_u2 <= acc_q[18:0]; r_job <= JB_T0; r_state <= ST_MAC;
                        end
                        JB_T0: begin
                            r_t0 <= acc_sat; r_job <= JB_T1; r_state <= ST_MAC;
                        end
                        JB_T1: begin
                            r_t1 <= acc_sat; r_job <= JB_T2; r_state <= ST_MAC;
                        end
                        default: begin
                            r_t2    <= acc_sat;
                            r_row   <= '0;
                            r_state <= ST_OUT;
                        end
                    endcase
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        r_n     <= sq_root;
                        r_didx  <= '0;
                        r_dload <= 1'b1;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dload) begin
                        r_dload <= 1'b0;
                        r_dneg  <= div_w[32];
                        r_rem   <= {1'b0, div_num[47:17]};
                        r_dnum  <= div_num[16:0];
                        r_q     <= '0;
                        r_dcnt  <= '0;
                    end else begin
                        r_rem  <= div_fit ? 32'(div_sh - {1'b0, r_n}) : div_sh[31:0];
                        r_dnum <= {r_dnum[15:0], 1'b0};
                        r_q    <= div_qn;
                        r_dcnt <= r_dcnt + 1'b1;
                        if (r_dcnt == 5'd16) begin
                            if (!r_dsel_s) begin
                                case (r_didx)
                                    2'd0:    r_v0 <= 33'(div_res);
                                    2'd1:    r_v1 <= 33'(div_res);
                                    default: begin
                                        r_v2 <= 33'(div_res);
                                        r_sx <= -div_res;
                                        r_sz <= r_v0[17:0];
                                    end
                                endcase
                            end else if (r_didx == 2'd0) begin
                                r_sx <= div_res;
                            end else begin
                                r_sz <= div_res;
                            end
                            if (div_last) begin
                                r_k     <= '0;
                                r_job   <= r_dsel_s ? JB_U0 : JB_SQS;
                                r_state <= ST_MAC;
                            end else begin
                                r_didx  <= r_didx + 1'b1;
                                r_dload <= 1'b1;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    r_strobe    <= 1'b1;
                    r_row_index <= r_row;
                    r_last_row  <= (r_row == 2'd3);
                    case (r_row)
                        2'd0: begin
                            r_col0 <= 32'(r_sx); r_col1 <= '0;
                            r_col2 <= 32'(r_sz); r_col3 <= r_t0;
                        end
                        2'd1: begin
                            r_col0 <= 32'(r_u0); r_col1 <= 32'(r_u1);
                            r_col2 <= 32'(r_u2); r_col3 <= r_t1;
                        end
                        2'd2: begin
                            r_col0 <= 32'(-r_v0); r_col1 <= 32'(-r_v1);
                            r_col2 <= 32'(-r_v2); r_col3 <= r_t2;
                        end
                        default: begin
                            r_col0 <= '0; r_col1 <= '0;
                            r_col2 <= '0; r_col3 <= ONE_Q16;
                        end
                    endcase
                    if (r_row == 2'd3) begin
                        r_state <= ST_IDLE;
                    end
                    r_row <= r_row + 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ design/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// look-at view matrix toward the origin with fixed world up, four Q16.16 rows
//
// channel   direction  handshake               payload
// position  in         start high, busy low    i_pos_x, i_pos_y, i_pos_z
// row       out        o_strobe for one cycle  o_row_index, o_col0..3, o_last_row
//
// for a transaction the back sequencer runs two square roots, five divisions
// and the multiply-accumulate passes; one square root and three divisions on
// the y axis, no square root or division at the origin; the four rows leave on
// consecutive cycles; the front register and queue take new positions while the back works
// reset is synchronous and clears control state only; rows cannot be stalled
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_strobe,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);

    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    logic      f_push;
    t_lav_item f_item;
    t_lav_item q_item;

    lav_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (f_push),
        .o_item  (f_item)
    );

    lav_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lav_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_row_index (o_row_index),
        .o_col0      (o_col0),
        .o_col1      (o_col1),
        .o_col2      (o_col2),
        .o_col3      (o_col3),
        .o_last_row  (o_last_row)
    );

endmodule
